// ===== rtl/spfa_pkg.sv =====
// Package: transaction types and format constants for the float ALU.
package spfa_pkg;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [7:0]  EXP_MAX = 8'hFF;
    localparam logic [9:0]  EXP_BIAS = 10'd127;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } t_req;

    typedef struct packed {
        logic [31:0] result_word;
        logic        overflow_flag;
        logic        underflow_flag;
    } t_rsp;

endpackage

// ===== rtl/spfa_core.sv =====
// Sequencer and shared shift/add unit: add, multiply, divide one bit per cycle.
module spfa_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  spfa_pkg::t_req i_req,
    output logic          o_done,
    output spfa_pkg::t_rsp o_rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADDN = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]  r_state;
    logic [4:0]  r_cnt;
    logic        r_sign;
    logic [9:0]  r_exp;      // signed exponent
    logic [47:0] r_acc;      // product / remainder / sum magnitude
    logic [23:0] r_mb;
    logic [23:0] r_mq;       // multiplier bits or quotient
    logic        r_done;
    spfa_pkg::t_rsp r_rsp;

    // operand decode
    logic        sa, sb, za, zb;
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic [31:0] bw;
    logic [7:0]  d;
    logic [23:0] ash, bsh;
    logic [25:0] sumv;
    logic [9:0]  eadd, emul, ediv;
    logic [24:0] trial;

    always_comb begin
        bw   = (i_req.req_type == spfa_pkg::OP_SUB) ? (i_req.operand_b ^ 32'h8000_0000)
                                                    : i_req.operand_b;
        sa   = i_req.operand_a[31];
        sb   = bw[31];
        za   = (i_req.operand_a[30:0] == 31'd0);
        zb   = (bw[30:0] == 31'd0);
        ea   = i_req.operand_a[30:23];
        eb   = bw[30:23];
        ma   = {1'b1, i_req.operand_a[22:0]};
        mb   = {1'b1, bw[22:0]};
        d    = (ea < eb) ? (eb - ea) : (ea - eb);
        ash  = (ea < eb) ? ((d >= 8'd24) ? 24'd0 : (ma >> d)) : ma;
        bsh  = (ea < eb) ? mb : ((d >= 8'd24) ? 24'd0 : (mb >> d));
        eadd = {2'b00, (ea < eb) ? eb : ea};
        emul = {2'b00, ea} + {2'b00, eb} - spfa_pkg::EXP_BIAS;
        ediv = {2'b00, ea} - {2'b00, eb} + spfa_pkg::EXP_BIAS;
        // signed sum of aligned significands
        sumv = (sa ? -{2'b00, ash} : {2'b00, ash}) + (sb ? -{2'b00, bsh} : {2'b00, bsh});
        trial = r_acc[24:0] - {1'b0, r_mb};
    end

    function automatic spfa_pkg::t_rsp lim(input logic s, input logic [9:0] e,
                                           input logic [22:0] f);
        spfa_pkg::t_rsp r;
        r = '0;
        if (!e[9] && e >= 10'd255) begin
            r.overflow_flag = 1'b1;
            r.result_word   = {s, spfa_pkg::EXP_MAX, 23'd0};
        end else if (e[9] || e == 10'd0) begin
            r.underflow_flag = 1'b1;
        end else begin
            r.result_word = {s, e[7:0], f};
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_cnt <= 5'd0;
                        if (i_req.req_type == spfa_pkg::OP_ADD ||
                            i_req.req_type == spfa_pkg::OP_SUB) begin
                            r_exp <= eadd;
                            r_sign <= sumv[25];
                            r_acc <= {22'd0, sumv[25] ? -sumv : sumv};
                            if (za) begin
                                r_rsp <= '{result_word: bw, overflow_flag: 1'b0,
                                           underflow_flag: 1'b0};
                                r_state <= S_FIN;
                            end else if (zb) begin
                                r_rsp <= '{result_word: i_req.operand_a, overflow_flag: 1'b0,
                                           underflow_flag: 1'b0};
                                r_state <= S_FIN;
                            end else if (sumv == 26'd0) begin
                                r_rsp <= '0;
                                r_state <= S_FIN;
                            end else begin
                                r_state <= S_ADDN;
                            end
                        end else if (i_req.req_type == spfa_pkg::OP_MUL) begin
                            r_sign <= sa ^ sb;
                            r_exp  <= emul;
                            r_acc  <= '0;
                            r_mb   <= mb;
                            r_mq   <= ma;
                            if (za || zb) begin
                                r_rsp <= '0; r_state <= S_FIN;
                            end else if (emul[9] || emul == 10'd0 || emul >= 10'd255) begin
                                r_rsp <= lim(sa ^ sb, emul, 23'd0); r_state <= S_FIN;
                            end else begin
                                r_state <= S_MUL;
                            end
                        end else begin
                            r_sign <= sa ^ sb;
                            r_exp  <= ediv;
                            r_acc  <= {24'd0, ma};
                            r_mb   <= mb;
                            r_mq   <= '0;
                            if (zb) begin
                                r_rsp <= '{result_word: {sa, spfa_pkg::EXP_MAX, 23'd0},
                                           overflow_flag: 1'b1, underflow_flag: 1'b0};
                                r_state <= S_FIN;
                            end else if (za) begin
                                r_rsp <= '0; r_state <= S_FIN;
                            end else if (ediv[9] || ediv == 10'd0 || ediv >= 10'd255) begin
                                r_rsp <= lim(sa ^ sb, ediv, 23'd0); r_state <= S_FIN;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                    end
                end
                // normalise sum one bit per cycle
                S_ADDN: begin
                    if (r_acc[24]) begin
                        r_rsp <= lim(r_sign, r_exp + 10'd1, r_acc[23:1]);
                        r_state <= S_FIN;
                    end else if (r_acc[23]) begin
                        r_rsp <= lim(r_sign, r_exp, r_acc[22:0]);
                        r_state <= S_FIN;
                    end else begin
                        r_acc <= r_acc << 1;
                        r_exp <= r_exp - 10'd1;
                    end
                end
                // shift-add multiply, multiplier LSB first
                S_MUL: begin
                    if (r_cnt == 5'd24) begin
                        if (r_acc[47]) r_rsp <= lim(r_sign, r_exp + 10'd1, r_acc[46:24]);
                        else r_rsp <= lim(r_sign, r_exp, r_acc[45:23]);
                        r_state <= S_FIN;
                    end else begin
                        r_acc <= {1'b0, r_acc[47:1]} +
                                 (r_mq[0] ? {1'b0, r_mb, 23'd0} : 48'd0);
                        r_mq  <= r_mq >> 1;
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                // restoring divide, one quotient bit per cycle
                S_DIV: begin
                    if (r_cnt == 5'd24) begin
                        if (r_mq[23]) r_rsp <= lim(r_sign, r_exp, r_mq[22:0]);
                        else r_rsp <= lim(r_sign, r_exp - 10'd1, {r_mq[21:0], 1'b0});
                        r_state <= S_FIN;
                    end else begin
                        if (!trial[24]) begin
                            r_acc <= {23'd0, trial[23:0], 1'b0};
                            r_mq  <= {r_mq[22:0], 1'b1};
                        end else begin
                            r_acc <= {23'd0, r_acc[23:0], 1'b0};
                            r_mq  <= {r_mq[22:0], 1'b0};
                        end
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ===== rtl/single_precision_float_alu_unit.sv =====
// Top level: truncating single-precision float ALU with one output register.
// Input channel i_valid/o_stall carries a request transaction (op, A, B); the
// output channel o_valid/i_stall carries result word and two flags.
// One transaction at a time: o_stall is high from acceptance until the result
// has been taken. Zero or limit cases go from the idle state straight to the
// finish state; add/subtract normalise in S_ADDN, one left shift per step;
// multiply and divide run in S_MUL or S_DIV, where the shared shift/add
// datapath retires one multiplier or quotient bit each cycle over 24 bits.
// A new request is taken only after the previous result has been taken.
// Reset (synchronous, active low) drops o_valid and returns to idle.
// While the receiver stalls, the result holds in the output register and
// no new request is taken.
module single_precision_float_alu_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  spfa_pkg::t_req i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output spfa_pkg::t_rsp o_data
);

    logic r_busy, r_valid, done;
    spfa_pkg::t_rsp rsp, r_out;
    logic start;

    assign start = i_valid && !r_busy;

    spfa_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_req(i_data),
        .o_done(done), .o_rsp(rsp)
    );

    // busy from accept to output handoff
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (start) r_busy <= 1'b1;
            if (done) begin
                r_valid <= 1'b1;
                r_out   <= rsp;
            end else if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
                r_busy  <= 1'b0;
            end
        end
    end

    assign o_stall = r_busy;
    assign o_valid = r_valid;
    assign o_data  = r_out;

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("result without busy");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> !o_valid) else $error("result too early");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.overflow_flag && o_data.underflow_flag))
        else $error("both flags set");

endmodule

// ===== tb/sv/single_precision_float_alu_unit_tb.sv =====
// Testbench for the truncating single-precision float ALU: predictor and scoreboard.
`timescale 1ns / 100ps

module single_precision_float_alu_unit_tb;

    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    spfa_pkg::t_req i_data;
    logic o_valid;
    logic i_stall;
    spfa_pkg::t_rsp o_data;

    single_precision_float_alu_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    spfa_pkg::t_req pending_reqs[$];
    spfa_pkg::t_rsp expected_results[$];
    int   error_count;
    int   sent_count;
    int   result_count;
    int   op_count[4];
    int   flag_count;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_off_cycles;
    bit   pause_sender;
    bit   stim_done;
    int   idle_cycles;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Limit check and result word assembly
    function automatic spfa_pkg::t_rsp finish_word(logic sgn, int e, logic [31:0] sig);
        spfa_pkg::t_rsp r;
        r = '0;
        if (e >= 255) begin
            r.overflow_flag = 1'b1;
            r.result_word = {sgn, 8'hFF, 23'd0};
        end else if (e <= 0) begin
            r.underflow_flag = 1'b1;
        end else begin
            r.result_word = {sgn, e[7:0], sig[22:0]};
        end
        return r;
    endfunction

    // Expected ALU result for one request
    function automatic spfa_pkg::t_rsp predict_alu(spfa_pkg::t_req q);
        spfa_pkg::t_rsp r;
        logic [31:0] a, b;
        logic sa, sb, sgn;
        int ea, eb, e, d;
        logic [31:0] ma, mb, mag;
        longint sum;
        logic [63:0] p;
        r = '0;
        a = q.operand_a;
        b = q.operand_b;
        if (q.req_type == spfa_pkg::OP_SUB) b[31] = ~b[31];
        sa = a[31];
        sb = b[31];
        ea = int'(a[30:23]);
        eb = int'(b[30:23]);
        ma = {9'd1, a[22:0]};
        mb = {9'd1, b[22:0]};
        sgn = a[31] ^ b[31];
        case (q.req_type)
            spfa_pkg::OP_ADD, spfa_pkg::OP_SUB: begin
                if (a[30:0] == 0) begin
                    r.result_word = b;
                end else if (b[30:0] == 0) begin
                    r.result_word = a;
                end else begin
                    if (ea < eb) begin
                        d = eb - ea;
                        ma = (d >= 24) ? 0 : ma >> d;
                        e = eb;
                    end else begin
                        d = ea - eb;
                        mb = (d >= 24) ? 0 : mb >> d;
                        e = ea;
                    end
                    sum = (sa ? -longint'(ma) : longint'(ma))
                        + (sb ? -longint'(mb) : longint'(mb));
                    if (sum != 0) begin
                        sgn = (sum < 0);
                        mag = sgn ? 32'(-sum) : 32'(sum);
                        if (mag[24]) begin
                            mag = mag >> 1;
                            e++;
                        end else begin
                            while (!mag[23]) begin
                                mag = mag << 1;
                                e--;
                            end
                        end
                        r = finish_word(sgn, e, mag);
                    end
                end
            end
            spfa_pkg::OP_MUL: begin
                if (a[30:0] != 0 && b[30:0] != 0) begin
                    e = ea + eb - 127;
                    if (e >= 255 || e <= 0) begin
                        r = finish_word(sgn, e, 0);
                    end else begin
                        p = (64'(ma) * 64'(mb)) >> 23;
                        if (p[24]) begin
                            p = p >> 1;
                            e++;
                        end
                        r = finish_word(sgn, e, p[31:0]);
                    end
                end
            end
            default: begin
                if (b[30:0] == 0) begin
                    r.overflow_flag = 1'b1;
                    r.result_word = {a[31], 8'hFF, 23'd0};
                end else if (a[30:0] != 0) begin
                    e = ea - eb + 127;
                    if (e >= 255 || e <= 0) begin
                        r = finish_word(sgn, e, 0);
                    end else begin
                        p = (64'(ma) << 23) / 64'(mb);
                        if (!p[23]) begin
                            p = p << 1;
                            e--;
                        end
                        r = finish_word(sgn, e, p[31:0]);
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Random operand with bias towards interesting exponents
    function automatic logic [31:0] rand_operand();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0: w[30:0] = 31'd0;
            1: w[30:23] = 8'h00;
            2: w[30:23] = 8'hFF;
            3: w[30:23] = 8'($urandom_range(0, 10));
            4: w[30:23] = 8'($urandom_range(245, 255));
            5, 6, 7: w[30:23] = 8'($urandom_range(100, 154));
            default: ;
        endcase
        return w;
    endfunction

    task automatic queue_req(logic [1:0] op, logic [31:0] a, logic [31:0] b);
        spfa_pkg::t_req q;
        q.req_type = op;
        q.operand_a = a;
        q.operand_b = b;
        pending_reqs.push_back(q);
    endtask

    task automatic queue_random(int n);
        logic [31:0] a;
        repeat (n) begin
            a = rand_operand();
            // Near-equal operands reach long normalisation shifts
            if ($urandom_range(0, 7) == 0)
                queue_req(2'($urandom_range(0, 3)), a, a ^ ($urandom & 32'h8000_00FF));
            else
                queue_req(2'($urandom_range(0, 3)), a, rand_operand());
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_results.size() != 0 || i_valid)
            @(posedge i_clk);
    endtask

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            sent_count <= sent_count + 1;
            expected_results.push_back(predict_alu(i_data));
            op_count[i_data.req_type] <= op_count[i_data.req_type] + 1;
            if (pending_reqs.size() != 0 && !pause_sender
                && $urandom_range(0, 99) >= send_idle_pct) begin
                i_data <= pending_reqs.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end else if (!i_valid && pending_reqs.size() != 0 && !pause_sender
                     && $urandom_range(0, 99) >= send_idle_pct) begin
            i_valid <= 1'b1;
            i_data <= pending_reqs.pop_front();
        end
    end

    // Receiver stall generation, with an optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            i_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Monitor and scoreboard
    always @(posedge i_clk) begin
        spfa_pkg::t_rsp exp_rsp;
        if (i_rst_n && o_valid && !i_stall) begin
            result_count <= result_count + 1;
            if (expected_results.size() == 0) begin
                $error("result transaction with nothing expected: %h", o_data);
                error_count++;
            end else begin
                exp_rsp = expected_results.pop_front();
                if (exp_rsp.overflow_flag || exp_rsp.underflow_flag) flag_count++;
                if (o_data.result_word !== exp_rsp.result_word) begin
                    $error("result_word expected %h actual %h",
                           exp_rsp.result_word, o_data.result_word);
                    error_count++;
                end
                if (o_data.overflow_flag !== exp_rsp.overflow_flag) begin
                    $error("overflow_flag expected %b actual %b",
                           exp_rsp.overflow_flag, o_data.overflow_flag);
                    error_count++;
                end
                if (o_data.underflow_flag !== exp_rsp.underflow_flag) begin
                    $error("underflow_flag expected %b actual %b",
                           exp_rsp.underflow_flag, o_data.underflow_flag);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding",
                     expected_results.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus sequence
    initial begin
        error_count = 0;
        sent_count = 0;
        result_count = 0;
        flag_count = 0;
        op_count = '{default: 0};
        send_idle_pct = 17;
        recv_idle_pct = 88;
        hold_off_cycles = 0;
        pause_sender = 1'b0;
        stim_done = 1'b0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zeros, extremes, cancellation, limits, divide by zero
        queue_req(spfa_pkg::OP_ADD, 32'h0000_0000, 32'h3F80_0000);
        queue_req(spfa_pkg::OP_SUB, 32'h0000_0000, 32'h3F80_0000);
        queue_req(spfa_pkg::OP_ADD, 32'hC040_0000, 32'h8000_0000);
        queue_req(spfa_pkg::OP_SUB, 32'h3F80_0000, 32'h3F80_0000);
        queue_req(spfa_pkg::OP_ADD, 32'h3F80_0000, 32'hBF80_0000);
        queue_req(spfa_pkg::OP_ADD, 32'h3F80_0000, 32'h3F80_0000);
        queue_req(spfa_pkg::OP_ADD, 32'h4B80_0000, 32'h3F80_0000);
        queue_req(spfa_pkg::OP_ADD, 32'h3F80_0001, 32'hBF80_0000);
        queue_req(spfa_pkg::OP_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
        queue_req(spfa_pkg::OP_SUB, 32'h0080_0001, 32'h0080_0000);
        queue_req(spfa_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        queue_req(spfa_pkg::OP_ADD, 32'h0000_0001, 32'h0000_0002);
        queue_req(spfa_pkg::OP_MUL, 32'h0000_0000, 32'h4000_0000);
        queue_req(spfa_pkg::OP_MUL, 32'h3FFF_FFFF, 32'h3FFF_FFFF);
        queue_req(spfa_pkg::OP_MUL, 32'h7F00_0000, 32'h4000_0000);
        queue_req(spfa_pkg::OP_MUL, 32'h0080_0000, 32'h0080_0000);
        queue_req(spfa_pkg::OP_MUL, 32'hC000_0000, 32'h4040_0000);
        queue_req(spfa_pkg::OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(spfa_pkg::OP_DIV, 32'hC000_0000, 32'h0000_0000);
        queue_req(spfa_pkg::OP_DIV, 32'h0000_0000, 32'h4000_0000);
        queue_req(spfa_pkg::OP_DIV, 32'h3F80_0000, 32'h3FFF_FFFF);
        queue_req(spfa_pkg::OP_DIV, 32'h7F00_0000, 32'h0080_0000);
        queue_req(spfa_pkg::OP_DIV, 32'h0080_0000, 32'h7F00_0000);
        queue_req(spfa_pkg::OP_DIV, 32'hFFFF_FFFF, 32'h0000_0001);
        queue_random(500);
        wait_drained();

        // Sender paused after all results have come, then a long receiver hold-off
        pause_sender = 1'b1;
        repeat (20) @(posedge i_clk);
        pause_sender = 1'b0;
        send_idle_pct = 88;
        recv_idle_pct = 17;
        hold_off_cycles <= 300;
        send_idle_pct = 0;
        queue_random(20);
        wait_drained();
        send_idle_pct = 88;
        queue_random(500);
        wait_drained();

        // Full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(510);
        wait_drained();
        repeat (40) @(posedge i_clk);

        if (expected_results.size() != 0 || result_count != sent_count) begin
            $error("results outstanding: expected %0d actual %0d",
                   sent_count, result_count);
            error_count++;
        end

        $display("sent %0d requests (add %0d sub %0d mul %0d div %0d), %0d results, %0d flagged",
                 sent_count, op_count[0], op_count[1], op_count[2], op_count[3],
                 result_count, flag_count);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
